/* rtl/subset_sum_enumerator_top_defines.svh */
// ----------------------------------------------------------------------------
// Subset-sum enumerator assertion macros
// Shared assertion forms for the enumerator RTL.
// ----------------------------------------------------------------------------
`ifndef SUBSET_SUM_ENUMERATOR_TOP_DEFINES_SVH
`define SUBSET_SUM_ENUMERATOR_TOP_DEFINES_SVH

// holds at every edge out of reset
`define SSENUM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SSENUM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/ssenum_pkg.sv */
// ----------------------------------------------------------------------------
// Subset-sum enumerator package
// Shared widths, opcodes and the adder unit's control and flag types.
// ----------------------------------------------------------------------------
package ssenum_pkg;

    localparam int TARGET_W = 20;
    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic fits;
        logic hit;
    } alu_flags_t;

endpackage

/* rtl/subset_sum_enumerator_top.sv */
// Next: a candidate try passes S_FETCH, S_TRY; a backtrack pop S_FETCH, S_POP_VAL,
// S_POP_SUB; a reported element S_OUT_STK, S_OUT_VAL, S_OUT_EMIT; so latency depends
// on the data (exponential worst case). The block takes one transfer at a time and is
// not ready during a search or a target write; the shared adder and the element/stack
// memories set the step cost. Synchronous active-low reset clears count, search state
// and target (to 1); memories are not cleared.
// ----------------------------------------------------------------------------
// Subset-sum enumerator top level
// Depth-first backtracking search over loaded elements under a sequencer.
// ----------------------------------------------------------------------------
`include "subset_sum_enumerator_top_defines.svh"

module subset_sum_enumerator_top
    import ssenum_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16,
    parameter int VALUE_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [TARGET_W-1:0] cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // [15:0] value
    input  logic                s_axis_tuser,  // [0] operation
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,  // [3:0] element_index, [19:4] element_value
    output logic                m_axis_tuser,  // [0] found
    output logic                m_axis_tlast
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_TRY,
        S_POP_VAL,
        S_POP_SUB,
        S_OUT_STK,
        S_OUT_VAL,
        S_OUT_EMIT,
        S_NONE
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    depth_reg;
    logic [CNT_W-1:0]    cand_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [TARGET_W-1:0] partial_reg;
    logic [TARGET_W-1:0] target_reg;
    logic                exhausted_reg;

    logic                m_valid_reg;
    logic                m_found_reg;
    logic [INDEX_W-1:0]  m_idx_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_last_reg;

    logic [VALUE_BITS-1:0] store_mem [MAX_ELEMENTS];
    logic [IDX_W-1:0]      stack_mem [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] store_rdata_reg;
    logic [IDX_W-1:0]      stk_rdata_reg;

    logic             in_xfer;
    logic             slot_free;
    logic             m_load;
    logic             can_take;
    logic             store_we;
    logic             store_re;
    logic             stk_we;
    logic             stk_re;
    logic [IDX_W-1:0] store_raddr;
    logic [IDX_W-1:0] stk_raddr;
    logic [CNT_W-1:0] depth_m1;
    logic [CNT_W-1:0] stk_next_cand;

    alu_op_t             alu_op;
    logic [TARGET_W-1:0] alu_result;
    alu_flags_t          alu_flags;

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_we;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign m_load        = slot_free && !cfg_we &&
                           ((state_reg == S_OUT_EMIT) || (state_reg == S_NONE));
    assign can_take      = (cand_reg < count_reg) && (depth_reg < MAX_CNT);
    assign depth_m1      = depth_reg - 1'b1;
    assign stk_next_cand = CNT_W'(stk_rdata_reg) + 1'b1;

    assign store_we    = in_xfer && (s_axis_tuser == OP_LOAD) && (count_reg < MAX_CNT);
    assign store_re    = ((state_reg == S_FETCH) && can_take) ||
                         (state_reg == S_POP_VAL) || (state_reg == S_OUT_VAL);
    assign store_raddr = (state_reg == S_FETCH) ? cand_reg[IDX_W-1:0] : stk_rdata_reg;

    assign stk_we    = (state_reg == S_TRY) && alu_flags.fits && !cfg_we;
    assign stk_re    = ((state_reg == S_FETCH) && !can_take && (depth_reg != '0)) ||
                       (state_reg == S_OUT_STK);
    assign stk_raddr = (state_reg == S_FETCH) ? depth_m1[IDX_W-1:0] : k_reg[IDX_W-1:0];

    assign alu_op = ((state_reg == S_POP_SUB) || (state_reg == S_OUT_EMIT)) ? ALU_SUB : ALU_ADD;

    ssenum_alu #(
        .VALUE_BITS (VALUE_BITS)
    ) u_alu (
        .op      (alu_op),
        .partial (partial_reg),
        .operand (store_rdata_reg),
        .target  (target_reg),
        .result  (alu_result),
        .flags   (alu_flags)
    );

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[count_reg[IDX_W-1:0]] <= VALUE_BITS'(s_axis_tdata);
        end
        if (store_re) begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[depth_reg[IDX_W-1:0]] <= cand_reg[IDX_W-1:0];
        end
        if (stk_re) begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            depth_reg     <= '0;
            cand_reg      <= '0;
            k_reg         <= '0;
            partial_reg   <= '0;
            target_reg    <= TARGET_W'(1);
            exhausted_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_found_reg   <= 1'b0;
            m_idx_reg     <= '0;
            m_value_reg   <= '0;
            m_last_reg    <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                target_reg    <= (cfg_wdata == '0) ? TARGET_W'(1) : cfg_wdata;
                depth_reg     <= '0;
                partial_reg   <= '0;
                cand_reg      <= '0;
                exhausted_reg <= 1'b0;
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (in_xfer) begin
                            if (s_axis_tuser == OP_LOAD) begin
                                if (count_reg < MAX_CNT) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                depth_reg     <= '0;
                                partial_reg   <= '0;
                                cand_reg      <= '0;
                                exhausted_reg <= 1'b0;
                            end else if (exhausted_reg) begin
                                state_reg <= S_NONE;
                            end else begin
                                state_reg <= S_FETCH;
                            end
                        end
                    end
                    S_FETCH: begin
                        if (can_take) begin
                            state_reg <= S_TRY;
                        end else if (depth_reg == '0) begin
                            exhausted_reg <= 1'b1;
                            state_reg     <= S_NONE;
                        end else begin
                            state_reg <= S_POP_VAL;
                        end
                    end
                    S_TRY: begin
                        cand_reg <= cand_reg + 1'b1;
                        if (alu_flags.fits) begin
                            depth_reg   <= depth_reg + 1'b1;
                            partial_reg <= alu_result;
                            if (alu_flags.hit) begin
                                k_reg     <= '0;
                                state_reg <= S_OUT_STK;
                            end else begin
                                state_reg <= S_FETCH;
                            end
                        end else begin
                            state_reg <= S_FETCH;
                        end
                    end
                    S_POP_VAL: begin
                        state_reg <= S_POP_SUB;
                    end
                    S_POP_SUB: begin
                        partial_reg <= alu_result;
                        depth_reg   <= depth_m1;
                        cand_reg    <= stk_next_cand;
                        state_reg   <= S_FETCH;
                    end
                    S_OUT_STK: begin
                        state_reg <= S_OUT_VAL;
                    end
                    S_OUT_VAL: begin
                        state_reg <= S_OUT_EMIT;
                    end
                    S_OUT_EMIT: begin
                        if (slot_free) begin
                            m_found_reg <= 1'b1;
                            m_idx_reg   <= INDEX_W'(stk_rdata_reg);
                            m_value_reg <= VALUE_W'(store_rdata_reg);
                            if ((k_reg + 1'b1) == depth_reg) begin
                                // last element is the stack top: pop it straight away
                                m_last_reg  <= 1'b1;
                                partial_reg <= alu_result;
                                depth_reg   <= depth_m1;
                                cand_reg    <= stk_next_cand;
                                state_reg   <= S_IDLE;
                            end else begin
                                m_last_reg <= 1'b0;
                                k_reg      <= k_reg + 1'b1;
                                state_reg  <= S_OUT_STK;
                            end
                        end
                    end
                    S_NONE: begin
                        if (slot_free) begin
                            m_found_reg <= 1'b0;
                            m_idx_reg   <= '0;
                            m_value_reg <= '0;
                            m_last_reg  <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_value_reg, m_idx_reg};
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tlast  = m_last_reg;

    `SSENUM_ASSERT_ALWAYS(a_partial_fits, partial_reg <= target_reg, "partial sum above target")
    `SSENUM_ASSERT_ALWAYS(a_depth_bound, depth_reg <= MAX_CNT, "stack depth overflow")
    `SSENUM_ASSERT_ALWAYS(a_cand_bound, cand_reg <= count_reg, "candidate beyond element count")
    `SSENUM_ASSERT_IMPL(a_none_is_last, m_valid_reg && !m_found_reg, m_last_reg, "no-solution not last")

endmodule

/* rtl/ssenum_alu.sv */
// ----------------------------------------------------------------------------
// Subset-sum enumerator adder unit
// Shared add/subtract on the partial sum with compare against the target.
// ----------------------------------------------------------------------------
module ssenum_alu
    import ssenum_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  alu_op_t               op,
    input  logic [TARGET_W-1:0]   partial,
    input  logic [VALUE_BITS-1:0] operand,
    input  logic [TARGET_W-1:0]   target,
    output logic [TARGET_W-1:0]   result,
    output alu_flags_t            flags
);

    localparam int SUM_W = ((VALUE_BITS > TARGET_W) ? VALUE_BITS : TARGET_W) + 1;

    logic [SUM_W-1:0] sum;

    always_comb begin
        unique case (op)
            ALU_ADD: sum = SUM_W'(partial) + SUM_W'(operand);
            ALU_SUB: sum = SUM_W'(partial) - SUM_W'(operand);
            default: sum = SUM_W'(partial);
        endcase
    end

    assign result     = TARGET_W'(sum);
    assign flags.fits = (sum <= SUM_W'(target));
    assign flags.hit  = (sum == SUM_W'(target));

endmodule

/* bench/subset_sum_enumerator_top_tb.sv */
// ----------------------------------------------------------------------------
// Subset-sum enumerator testbench
// Loads elements and requests solutions over the input stream, rewrites the
// target between phases, and checks every result transfer against a
// backtracking predictor. Both stream sides idle at random, and the receiver
// holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module subset_sum_enumerator_top_tb;
    import ssenum_pkg::*;

    localparam int MAX_ELEMENTS  = 16;
    localparam int RANDOM_ITEMS  = 370;
    localparam int COST_CAP      = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 12000000;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } ssum_result_t;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } stim_item_t;

    class subset_sum_tracker;
        logic [VALUE_W-1:0] elem[MAX_ELEMENTS];
        logic [INDEX_W-1:0] chosen[MAX_ELEMENTS];
        logic [4:0]         elem_count;
        logic [4:0]         depth;
        logic [4:0]         cand;
        logic [20:0]        psum;
        logic [TARGET_W:0]  target;
        bit                 exhausted;
        ssum_result_t       solution_q[$];
        int                 errors;

        function new();
            elem_count = '0;
            target     = (TARGET_W+1)'(1);
            errors     = 0;
            restart();
        endfunction

        function void restart();
            depth     = '0;
            psum      = '0;
            cand      = '0;
            exhausted = 1'b0;
        endfunction

        function void drop_top();
            depth--;
            psum -= elem[chosen[depth]];
            cand = 5'(chosen[depth]) + 5'd1;
        endfunction

        function void set_target(logic [TARGET_W-1:0] v);
            target = (v == '0) ? (TARGET_W+1)'(1) : {1'b0, v};
            restart();
        endfunction

        function void note_transfer(logic op, logic [VALUE_W-1:0] value);
            ssum_result_t r;
            if (op == OP_LOAD) begin
                if (elem_count < MAX_ELEMENTS) begin
                    elem[elem_count] = value;
                    elem_count++;
                end
                restart();
                return;
            end
            while (!exhausted) begin
                if (cand < elem_count && depth < MAX_ELEMENTS) begin
                    if (psum + elem[cand] <= target) begin
                        chosen[depth] = cand[INDEX_W-1:0];
                        depth++;
                        psum += elem[cand];
                        cand++;
                        if (psum == target) begin
                            for (int k = 0; k < depth; k++) begin
                                r.found = 1'b1;
                                r.index = chosen[k];
                                r.value = elem[chosen[k]];
                                r.last  = (k + 1 == depth);
                                solution_q.push_back(r);
                            end
                            drop_top();
                            return;
                        end
                    end else begin
                        cand++;
                    end
                end else if (depth == 0) begin
                    exhausted = 1'b1;
                end else begin
                    drop_top();
                end
            end
            r = '0;
            r.last = 1'b1;
            solution_q.push_back(r);
        endfunction

        function void check_transfer(ssum_result_t r);
            ssum_result_t e;
            if (solution_q.size() == 0) begin
                $error("unexpected result transfer: found %0d index %0d value %0d last %0d",
                       r.found, r.index, r.value, r.last);
                errors++;
                return;
            end
            e = solution_q.pop_front();
            if (r.found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, r.found);
                errors++;
            end
            if (r.index !== e.index) begin
                $error("element_index: expected %0d, actual %0d", e.index, r.index);
                errors++;
            end
            if (r.value !== e.value) begin
                $error("element_value: expected %0d, actual %0d", e.value, r.value);
                errors++;
            end
            if (r.last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, r.last);
                errors++;
            end
        endfunction

        function int pending();
            return solution_q.size();
        endfunction

        // rough cycle cost of a full enumeration from restart with the current store
        function int unsigned search_cost(logic [TARGET_W-1:0] tgt_in);
            logic [INDEX_W-1:0] stk[MAX_ELEMENTS];
            logic [4:0]         d;
            logic [4:0]         c;
            logic [20:0]        s;
            logic [20:0]        t;
            int unsigned        cost;
            t = (tgt_in == '0) ? 21'd1 : {1'b0, tgt_in};
            d = '0;
            c = '0;
            s = '0;
            cost = 0;
            while (cost <= COST_CAP) begin
                if (c < elem_count && d < MAX_ELEMENTS) begin
                    cost += 2;
                    if (s + elem[c] <= t) begin
                        stk[d] = c[INDEX_W-1:0];
                        d++;
                        s += elem[c];
                        c++;
                        if (s == t) begin
                            cost += 3 * d;
                            d--;
                            s -= elem[stk[d]];
                            c = 5'(stk[d]) + 5'd1;
                        end
                    end else begin
                        c++;
                    end
                end else if (d == 0) begin
                    break;
                end else begin
                    cost += 3;
                    d--;
                    s -= elem[stk[d]];
                    c = 5'(stk[d]) + 5'd1;
                end
            end
            return cost;
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [TARGET_W-1:0] cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;  // [15:0] value
    logic                s_axis_tuser;  // [0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [23:0]         m_axis_tdata;  // [3:0] element_index, [19:4] element_value
    logic                m_axis_tuser;  // [0] found
    logic                m_axis_tlast;

    subset_sum_tracker sb;
    stim_item_t        stim_q[$];
    int                queued;
    int                accepted;
    int                results_seen;
    bit                in_taken;
    int unsigned       cycles;

    subset_sum_enumerator_top #(
        .MAX_ELEMENTS(MAX_ELEMENTS),
        .VALUE_BITS  (16)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_transfer(s_axis_tuser, s_axis_tdata);
                accepted++;
                in_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_transfer({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
                                   m_axis_tlast});
                results_seen++;
            end
        end
    end

    initial begin : sender
        stim_item_t item;
        int         burst_left;
        int         gap_left;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!s_axis_tvalid || in_taken) begin
                in_taken = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid = 1'b0;
                end else if (stim_q.size() > 0) begin
                    item = stim_q.pop_front();
                    s_axis_tuser  = item.op;
                    s_axis_tdata  = item.value;
                    s_axis_tvalid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 7);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid = 1'b0;
                end
            end
        end
    end

    initial begin : receiver
        int mode;
        int mode_left;
        bit hold_done;
        m_axis_tready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        hold_done     = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 40 && queued - accepted >= 3) begin
                // long hold-off: block fills and must stall its input
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                0: begin
                    m_axis_tready = 1'b1;
                end
                1: begin
                    m_axis_tready = 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** subset_sum_enumerator_top: FAILED **");
        $finish;
    end

    task automatic queue_item(logic op, logic [VALUE_W-1:0] value);
        stim_item_t item;
        item.op    = op;
        item.value = value;
        stim_q.push_back(item);
        queued++;
    endtask

    task automatic wait_drained();
        while (accepted != queued || sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_target(logic [TARGET_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        sb.set_target(v);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return VALUE_W'($urandom_range(1, 63));
        else if (pick < 9)
            return VALUE_W'($urandom_range(16'h8000, 16'hFFFF));
        else
            return VALUE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // prefer targets that some subset reaches; reject ones too slow to enumerate
    function automatic logic [TARGET_W-1:0] pick_target();
        logic [TARGET_W-1:0] t;
        int unsigned         acc;
        int                  kind;
        for (int tries = 0; tries < 12; tries++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                acc = 0;
                for (int i = 0; i < sb.elem_count; i++)
                    if ($urandom_range(0, 2) == 0) acc += sb.elem[i];
                if (acc == 0 && sb.elem_count > 0)
                    acc = sb.elem[$urandom_range(0, sb.elem_count - 1)];
                t = (acc == 0) ? TARGET_W'(1) : TARGET_W'(acc);
            end else if (kind < 7) begin
                t = TARGET_W'($urandom_range(1, (1 << $urandom_range(1, TARGET_W)) - 1));
            end else if (kind < 8) begin
                t = TARGET_W'($urandom);
            end else if (kind < 9) begin
                t = '0;
            end else begin
                t = '1;
            end
            if (sb.search_cost(t) <= COST_CAP) return t;
        end
        return TARGET_W'(1);
    endfunction

    initial begin : main
        int n;
        int random_items;
        sb           = new();
        queued       = 0;
        accepted     = 0;
        results_seen = 0;
        in_taken     = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // empty store, default target, then exhausted search
        queue_item(OP_NEXT, 16'h0000);
        queue_item(OP_LOAD, 16'd1);
        queue_item(OP_NEXT, 16'hFFFF);
        queue_item(OP_NEXT, 16'h0000);
        queue_item(OP_NEXT, 16'h0000);
        wait_drained();

        // zero target is held at one; zero-valued element
        write_target('0);
        queue_item(OP_LOAD, 16'd0);
        queue_item(OP_NEXT, 16'h0000);
        queue_item(OP_NEXT, 16'h0000);
        wait_drained();

        write_target('1);
        queue_item(OP_LOAD, 16'hFFFF);
        queue_item(OP_LOAD, 16'h5A5A);
        queue_item(OP_NEXT, 16'h0000);
        queue_item(OP_NEXT, 16'h0000);
        wait_drained();

        write_target(20'd65536);
        repeat (4) queue_item(OP_NEXT, 16'h0000);
        wait_drained();

        write_target(20'd65535);
        repeat (3) queue_item(OP_NEXT, 16'h0000);
        wait_drained();

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (sb.elem_count < MAX_ELEMENTS && $urandom_range(0, 1) == 1) begin
                n = $urandom_range(1, 2);
                repeat (n) begin
                    queue_item(OP_LOAD, random_value());
                    random_items++;
                end
                wait_drained();
            end
            write_target(pick_target());
            n = $urandom_range(4, 14);
            repeat (n) begin
                if (sb.elem_count == MAX_ELEMENTS && $urandom_range(0, 6) == 0)
                    queue_item(OP_LOAD, random_value());
                else
                    queue_item(OP_NEXT, VALUE_W'($urandom));
                random_items++;
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.pending() != 0) begin
            $error("%0d expected result transfers never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** subset_sum_enumerator_top: PASSED **");
        end else begin
            $display("** subset_sum_enumerator_top: FAILED **");
        end
        $finish;
    end

endmodule
